// File: hdl/sci_pkg.sv
package sci_pkg;

   // Field and datapath widths
   localparam int COORD_W = 16;   // Q7.8 coordinate
   localparam int RAD_W   = 15;   // unsigned Q7.8 radius
   localparam int DIFF_W  = 17;   // difference of two coordinates
   localparam int PROD_W  = 34;   // product of two differences
   localparam int RSQ_W   = 30;   // radius squared
   localparam int A_W     = 34;   // a = d.d, unsigned
   localparam int H_W     = 35;   // h = f.d and c = f.f - r^2, signed
   localparam int HALF_W  = 17;   // half of a split multiplicand
   localparam int WIDE_W  = 68;   // h^2 and a*|c|
   localparam int DISC_W  = 64;   // discriminant, always below 2^63
   localparam int ROOT_W  = 32;   // square root of the discriminant
   localparam int REM_W   = 36;   // square root remainder
   localparam int SQRT_STEPS = DISC_W / 2;
   localparam int NUM_SEL_W = 37; // candidate root numerator, signed
   localparam int TFRAC   = 16;   // fraction bits of t
   localparam int T_W     = 17;   // t, 65536 means one
   localparam int DEN_W   = A_W + 1;
   localparam int QUO_W   = A_W + T_W + 1;
   localparam int DIV_STEPS = T_W;
   localparam int PLACE_W = 35;   // d times t
   localparam int IDX_W   = 2;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_CENTER_X = 2'd0;
   localparam logic [IDX_W-1:0] REG_CENTER_Y = 2'd1;
   localparam logic [IDX_W-1:0] REG_RADIUS   = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic [RAD_W-1:0]          radius;
   } circle_type;

   // Data that travels with each segment down the pipeline
   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dy;
      logic [A_W-1:0]            a;
      logic signed [H_W-1:0]     h;
   } side_type;

endpackage

// File: hdl/sci_req_if.sv
interface sci_req_if;
   logic valid;
   logic ready;
   logic signed [sci_pkg::COORD_W-1:0] start_x;
   logic signed [sci_pkg::COORD_W-1:0] start_y;
   logic signed [sci_pkg::COORD_W-1:0] end_x;
   logic signed [sci_pkg::COORD_W-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// File: hdl/sci_rsp_if.sv
interface sci_rsp_if;
   logic valid;
   logic ready;
   logic signed [sci_pkg::COORD_W-1:0] hit_x;
   logic signed [sci_pkg::COORD_W-1:0] hit_y;
   logic [sci_pkg::T_W-1:0]            hit_t;

   modport source (output valid, hit_x, hit_y, hit_t, input ready);
   modport sink (input valid, hit_x, hit_y, hit_t, output ready);
endinterface

// File: hdl/sci_quad.sv
module sci_quad (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_vld,
   input  logic signed [sci_pkg::COORD_W-1:0] in_sx,
   input  logic signed [sci_pkg::COORD_W-1:0] in_sy,
   input  logic signed [sci_pkg::COORD_W-1:0] in_ex,
   input  logic signed [sci_pkg::COORD_W-1:0] in_ey,
   input  sci_pkg::circle_type                circle,
   output logic                               out_vld,
   output sci_pkg::side_type                  out_side,
   output logic [sci_pkg::DISC_W-1:0]         out_disc
);

   // stage 1: differences
   logic v1_ff;
   logic signed [sci_pkg::COORD_W-1:0] sx1_ff, sy1_ff;
   logic signed [sci_pkg::DIFF_W-1:0] dx1_ff, dy1_ff, fx1_ff, fy1_ff;
   logic signed [sci_pkg::DIFF_W-1:0] dx1_in, dy1_in, fx1_in, fy1_in;
   // stage 2: products
   logic v2_ff;
   logic signed [sci_pkg::COORD_W-1:0] sx2_ff, sy2_ff;
   logic signed [sci_pkg::DIFF_W-1:0] dx2_ff, dy2_ff;
   logic signed [sci_pkg::PROD_W-1:0] dxdx2_ff, dydy2_ff, fxdx2_ff, fydy2_ff;
   logic signed [sci_pkg::PROD_W-1:0] fxfx2_ff, fyfy2_ff;
   logic signed [sci_pkg::PROD_W-1:0] dxdx2_in, dydy2_in, fxdx2_in, fydy2_in;
   logic signed [sci_pkg::PROD_W-1:0] fxfx2_in, fyfy2_in;
   logic [sci_pkg::RSQ_W-1:0] r2_ff, r2_in;
   // stage 3: quadratic coefficients
   logic v3_ff;
   logic signed [sci_pkg::COORD_W-1:0] sx3_ff, sy3_ff;
   logic signed [sci_pkg::DIFF_W-1:0] dx3_ff, dy3_ff;
   logic [sci_pkg::A_W-1:0] a3_ff, a3_in;
   logic signed [sci_pkg::H_W-1:0] h3_ff, h3_in, c3_ff, c3_in;
   // stage 4: magnitudes
   logic v4_ff, cpos4_ff;
   sci_pkg::side_type side4_ff, side4_in;
   logic [sci_pkg::A_W-1:0] habs4_ff, habs4_in, cabs4_ff, cabs4_in;
   // stage 5: partial products
   logic v5_ff, cpos5_ff;
   sci_pkg::side_type side5_ff;
   logic [sci_pkg::PROD_W-1:0] hhh5_ff, hhl5_ff, hll5_ff;
   logic [sci_pkg::PROD_W-1:0] ahh5_ff, ahl5_ff, alh5_ff, all5_ff;
   // stage 6: h^2 and a*|c|
   logic v6_ff, cpos6_ff;
   sci_pkg::side_type side6_ff;
   logic [sci_pkg::WIDE_W-1:0] hh6_ff, hh6_in, ac6_ff, ac6_in;
   // stage 7: discriminant
   logic v7_ff, v7_in;
   sci_pkg::side_type side7_ff;
   logic [sci_pkg::DISC_W-1:0] disc7_ff, disc7_in;
   logic [sci_pkg::WIDE_W:0] diff7, sum7;

   // form differences
   always_comb begin
      dx1_in = $signed({in_ex[sci_pkg::COORD_W-1], in_ex}) -
               $signed({in_sx[sci_pkg::COORD_W-1], in_sx});
      dy1_in = $signed({in_ey[sci_pkg::COORD_W-1], in_ey}) -
               $signed({in_sy[sci_pkg::COORD_W-1], in_sy});
      fx1_in = $signed({in_sx[sci_pkg::COORD_W-1], in_sx}) -
               $signed({circle.center_x[sci_pkg::COORD_W-1], circle.center_x});
      fy1_in = $signed({in_sy[sci_pkg::COORD_W-1], in_sy}) -
               $signed({circle.center_y[sci_pkg::COORD_W-1], circle.center_y});
   end

   // multiply
   always_comb begin
      dxdx2_in = dx1_ff * dx1_ff;
      dydy2_in = dy1_ff * dy1_ff;
      fxdx2_in = fx1_ff * dx1_ff;
      fydy2_in = fy1_ff * dy1_ff;
      fxfx2_in = fx1_ff * fx1_ff;
      fyfy2_in = fy1_ff * fy1_ff;
      r2_in    = circle.radius * circle.radius;
   end

   // sum into a, h, c
   always_comb begin
      a3_in = $unsigned(dxdx2_ff) + $unsigned(dydy2_ff);
      h3_in = sci_pkg::H_W'(fxdx2_ff) + sci_pkg::H_W'(fydy2_ff);
      c3_in = sci_pkg::H_W'(fxfx2_ff) + sci_pkg::H_W'(fyfy2_ff) -
              $signed({5'b0, r2_ff});
   end

   // take magnitudes
   always_comb begin
      side4_in.sx = sx3_ff;
      side4_in.sy = sy3_ff;
      side4_in.dx = dx3_ff;
      side4_in.dy = dy3_ff;
      side4_in.a  = a3_ff;
      side4_in.h  = h3_ff;
      habs4_in = h3_ff[sci_pkg::H_W-1] ? sci_pkg::A_W'(-h3_ff) : sci_pkg::A_W'(h3_ff);
      cabs4_in = c3_ff[sci_pkg::H_W-1] ? sci_pkg::A_W'(-c3_ff) : sci_pkg::A_W'(c3_ff);
   end

   // combine partial products
   always_comb begin
      hh6_in = (sci_pkg::WIDE_W'(hhh5_ff) << (2 * sci_pkg::HALF_W)) +
               (sci_pkg::WIDE_W'(hhl5_ff) << (sci_pkg::HALF_W + 1)) +
               sci_pkg::WIDE_W'(hll5_ff);
      ac6_in = (sci_pkg::WIDE_W'(ahh5_ff) << (2 * sci_pkg::HALF_W)) +
               ((sci_pkg::WIDE_W'(ahl5_ff) + sci_pkg::WIDE_W'(alh5_ff)) << sci_pkg::HALF_W) +
               sci_pkg::WIDE_W'(all5_ff);
   end

   // discriminant, drop a miss
   always_comb begin
      diff7 = {1'b0, hh6_ff} - {1'b0, ac6_ff};
      sum7  = {1'b0, hh6_ff} + {1'b0, ac6_ff};
      if (cpos6_ff) begin
         v7_in    = v6_ff && !diff7[sci_pkg::WIDE_W];
         disc7_in = diff7[sci_pkg::DISC_W-1:0];
      end else begin
         v7_in    = v6_ff;
         disc7_in = sum7[sci_pkg::DISC_W-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_vld;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff && (a3_ff != '0);
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v7_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         sx1_ff <= in_sx;
         sy1_ff <= in_sy;
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;
         fx1_ff <= fx1_in;
         fy1_ff <= fy1_in;

         sx2_ff <= sx1_ff;
         sy2_ff <= sy1_ff;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         dxdx2_ff <= dxdx2_in;
         dydy2_ff <= dydy2_in;
         fxdx2_ff <= fxdx2_in;
         fydy2_ff <= fydy2_in;
         fxfx2_ff <= fxfx2_in;
         fyfy2_ff <= fyfy2_in;
         r2_ff    <= r2_in;

         sx3_ff <= sx2_ff;
         sy3_ff <= sy2_ff;
         dx3_ff <= dx2_ff;
         dy3_ff <= dy2_ff;
         a3_ff  <= a3_in;
         h3_ff  <= h3_in;
         c3_ff  <= c3_in;

         side4_ff <= side4_in;
         habs4_ff <= habs4_in;
         cabs4_ff <= cabs4_in;
         cpos4_ff <= !c3_ff[sci_pkg::H_W-1] && (c3_ff != '0);

         side5_ff <= side4_ff;
         cpos5_ff <= cpos4_ff;
         hhh5_ff <= habs4_ff[sci_pkg::A_W-1:sci_pkg::HALF_W] *
                    habs4_ff[sci_pkg::A_W-1:sci_pkg::HALF_W];
         hhl5_ff <= habs4_ff[sci_pkg::A_W-1:sci_pkg::HALF_W] *
                    habs4_ff[sci_pkg::HALF_W-1:0];
         hll5_ff <= habs4_ff[sci_pkg::HALF_W-1:0] * habs4_ff[sci_pkg::HALF_W-1:0];
         ahh5_ff <= side4_ff.a[sci_pkg::A_W-1:sci_pkg::HALF_W] *
                    cabs4_ff[sci_pkg::A_W-1:sci_pkg::HALF_W];
         ahl5_ff <= side4_ff.a[sci_pkg::A_W-1:sci_pkg::HALF_W] *
                    cabs4_ff[sci_pkg::HALF_W-1:0];
         alh5_ff <= side4_ff.a[sci_pkg::HALF_W-1:0] *
                    cabs4_ff[sci_pkg::A_W-1:sci_pkg::HALF_W];
         all5_ff <= side4_ff.a[sci_pkg::HALF_W-1:0] * cabs4_ff[sci_pkg::HALF_W-1:0];

         side6_ff <= side5_ff;
         cpos6_ff <= cpos5_ff;
         hh6_ff   <= hh6_in;
         ac6_ff   <= ac6_in;

         side7_ff <= side6_ff;
         disc7_ff <= disc7_in;
      end
   end

   assign out_vld  = v7_ff;
   assign out_side = side7_ff;
   assign out_disc = disc7_ff;

endmodule

// File: hdl/sci_sqrt.sv
module sci_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_vld,
   input  sci_pkg::side_type          in_side,
   input  logic [sci_pkg::DISC_W-1:0] in_disc,
   output logic                       out_vld,
   output sci_pkg::side_type          out_side,
   output logic [sci_pkg::ROOT_W-1:0] out_root
);

   localparam int N = sci_pkg::SQRT_STEPS;

   logic                       vld_ff  [N];
   sci_pkg::side_type          side_ff [N];
   logic [sci_pkg::REM_W-1:0]  rem_ff  [N];
   logic [sci_pkg::ROOT_W-1:0] root_ff [N];
   logic [sci_pkg::DISC_W-1:0] rad_ff  [N];

   logic                       round_vld_ff;
   sci_pkg::side_type          round_side_ff;
   logic [sci_pkg::ROOT_W-1:0] round_root_ff, round_root_in;

   // one result bit per stage
   for (genvar k = 0; k < N; k++) begin : g_step
      logic                       src_vld;
      sci_pkg::side_type          src_side;
      logic [sci_pkg::REM_W-1:0]  src_rem, rem_sh, trial, rem_in;
      logic [sci_pkg::ROOT_W-1:0] src_root, root_in;
      logic [sci_pkg::DISC_W-1:0] src_rad;
      logic                       ge;

      if (k == 0) begin : g_first
         assign src_vld  = in_vld;
         assign src_side = in_side;
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_rad  = in_disc;
      end else begin : g_next
         assign src_vld  = vld_ff[k-1];
         assign src_side = side_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_root = root_ff[k-1];
         assign src_rad  = rad_ff[k-1];
      end

      // bring down two bits, try the next root bit
      always_comb begin
         rem_sh  = {src_rem[sci_pkg::REM_W-3:0], src_rad[sci_pkg::DISC_W-1 -: 2]};
         trial   = sci_pkg::REM_W'({src_root, 2'b01});
         ge      = (rem_sh >= trial);
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {src_root[sci_pkg::ROOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= src_side;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {src_rad[sci_pkg::DISC_W-3:0], 2'b00};
         end
      end
   end

   // round to nearest: remainder above root means the upper neighbor is closer
   assign round_root_in = (rem_ff[N-1] > sci_pkg::REM_W'(root_ff[N-1])) ?
                          root_ff[N-1] + 1'b1 : root_ff[N-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         round_vld_ff <= 1'b0;
      end else if (adv) begin
         round_vld_ff <= vld_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         round_side_ff <= side_ff[N-1];
         round_root_ff <= round_root_in;
      end
   end

   assign out_vld  = round_vld_ff;
   assign out_side = round_side_ff;
   assign out_root = round_root_ff;

endmodule

// File: hdl/sci_div.sv
module sci_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_vld,
   input  sci_pkg::side_type         in_side,
   input  logic [sci_pkg::A_W-1:0]   in_num,
   output logic                      out_vld,
   output sci_pkg::side_type         out_side,
   output logic [sci_pkg::T_W-1:0]   out_t
);

   localparam int N = sci_pkg::DIV_STEPS;

   // setup stage: dividend n*2^17 + a, divisor 2a
   logic                        pre_vld_ff;
   sci_pkg::side_type           pre_side_ff;
   logic [sci_pkg::QUO_W-1:0]   pre_rem_ff, pre_rem_in;
   logic [sci_pkg::DEN_W-1:0]   pre_den_ff;

   logic                        vld_ff  [N];
   sci_pkg::side_type           side_ff [N];
   logic [sci_pkg::QUO_W-1:0]   rem_ff  [N];
   logic [sci_pkg::DEN_W-1:0]   den_ff  [N];
   logic [sci_pkg::T_W-1:0]     quo_ff  [N];

   assign pre_rem_in = (sci_pkg::QUO_W'(in_num) << (sci_pkg::TFRAC + 1)) +
                       sci_pkg::QUO_W'(in_side.a);

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= 1'b0;
      end else if (adv) begin
         pre_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_side_ff <= in_side;
         pre_rem_ff  <= pre_rem_in;
         pre_den_ff  <= {in_side.a, 1'b0};
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < N; k++) begin : g_step
      logic                      src_vld;
      sci_pkg::side_type         src_side;
      logic [sci_pkg::QUO_W-1:0] src_rem, shifted, rem_in;
      logic [sci_pkg::DEN_W-1:0] src_den;
      logic [sci_pkg::T_W-1:0]   src_quo;
      logic                      ge;

      if (k == 0) begin : g_first
         assign src_vld  = pre_vld_ff;
         assign src_side = pre_side_ff;
         assign src_rem  = pre_rem_ff;
         assign src_den  = pre_den_ff;
         assign src_quo  = '0;
      end else begin : g_next
         assign src_vld  = vld_ff[k-1];
         assign src_side = side_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_den  = den_ff[k-1];
         assign src_quo  = quo_ff[k-1];
      end

      always_comb begin
         shifted = sci_pkg::QUO_W'(src_den) << (N - 1 - k);
         ge      = (src_rem >= shifted);
         rem_in  = ge ? (src_rem - shifted) : src_rem;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= src_side;
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= src_den;
            quo_ff[k]  <= {src_quo[sci_pkg::T_W-2:0], ge};
         end
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_side = side_ff[N-1];
   assign out_t    = quo_ff[N-1];

endmodule

// File: hdl/segment_circle_intersection.sv
// Throughput: one segment per cycle while no result beat is stalled; the square
// root (32 result-bit stages and a rounding stage) and the divider (a setup stage
// and 17 quotient stages) are fully pipelined, so every stage advances together.
// A segment that misses makes no beat. A stalled result beat holds all stages.
// Reset (synchronous) empties the pipeline and clears the circle registers to 0.
module segment_circle_intersection (
   input  logic                             clock,
   input  logic                             reset,
   sci_req_if.sink                          req,
   sci_rsp_if.source                        rsp,
   input  logic                             csr_write_en,
   input  logic [sci_pkg::IDX_W-1:0]        csr_index,
   input  logic [sci_pkg::COORD_W-1:0]      csr_wdata
);

   logic adv;

   sci_pkg::circle_type circle_ff;

   logic                       quad_vld, sqrt_vld, div_vld;
   sci_pkg::side_type          quad_side, sqrt_side, div_side;
   logic [sci_pkg::DISC_W-1:0] quad_disc;
   logic [sci_pkg::ROOT_W-1:0] sqrt_root;
   logic [sci_pkg::T_W-1:0]    div_t;

   // root select stage
   logic                          sel_vld_ff, sel_vld_in;
   sci_pkg::side_type             sel_side_ff;
   logic [sci_pkg::A_W-1:0]       sel_num_ff, sel_num_in;
   logic signed [sci_pkg::NUM_SEL_W-1:0] hx, sx37, ax, n_near, n_far;
   logic                          ok_near, ok_far;

   // placement stage
   logic                           pl_vld_ff;
   logic signed [sci_pkg::COORD_W-1:0] pl_sx_ff, pl_sy_ff;
   logic signed [sci_pkg::PLACE_W-1:0] pl_px_ff, pl_py_ff, pl_px_in, pl_py_in;
   logic [sci_pkg::T_W-1:0]        pl_t_ff;
   logic signed [sci_pkg::T_W:0]   t_signed;

   // result register
   logic                               rsp_valid_ff;
   logic signed [sci_pkg::COORD_W-1:0] hit_x_ff, hit_y_ff, hit_x_in, hit_y_in;
   logic [sci_pkg::T_W-1:0]            hit_t_ff;
   logic signed [sci_pkg::PLACE_W-1:0] rx, ry;

   // advance whenever the result register is free or being drained
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   // circle registers
   always_ff @(posedge clock) begin
      if (reset) begin
         circle_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            sci_pkg::REG_CENTER_X: circle_ff.center_x <= csr_wdata;
            sci_pkg::REG_CENTER_Y: circle_ff.center_y <= csr_wdata;
            sci_pkg::REG_RADIUS:   circle_ff.radius   <= csr_wdata[sci_pkg::RAD_W-1:0];
            default: ;
         endcase
      end
   end

   sci_quad u_quad (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (req.valid),
      .in_sx    (req.start_x),
      .in_sy    (req.start_y),
      .in_ex    (req.end_x),
      .in_ey    (req.end_y),
      .circle   (circle_ff),
      .out_vld  (quad_vld),
      .out_side (quad_side),
      .out_disc (quad_disc)
   );

   sci_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (quad_vld),
      .in_side  (quad_side),
      .in_disc  (quad_disc),
      .out_vld  (sqrt_vld),
      .out_side (sqrt_side),
      .out_root (sqrt_root)
   );

   // pick the nearer root that lies on the segment, drop the segment if none
   always_comb begin
      hx      = sci_pkg::NUM_SEL_W'(sqrt_side.h);
      sx37    = $signed({5'b0, sqrt_root});
      ax      = $signed({3'b0, sqrt_side.a});
      n_near  = -hx - sx37;
      n_far   = -hx + sx37;
      ok_near = !n_near[sci_pkg::NUM_SEL_W-1] && (n_near <= ax);
      ok_far  = !n_far[sci_pkg::NUM_SEL_W-1] && (n_far <= ax);
      sel_vld_in = sqrt_vld && (ok_near || ok_far);
      sel_num_in = ok_near ? n_near[sci_pkg::A_W-1:0] : n_far[sci_pkg::A_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_vld_ff <= 1'b0;
      end else if (adv) begin
         sel_vld_ff <= sel_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sel_side_ff <= sqrt_side;
         sel_num_ff  <= sel_num_in;
      end
   end

   sci_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (sel_vld_ff),
      .in_side  (sel_side_ff),
      .in_num   (sel_num_ff),
      .out_vld  (div_vld),
      .out_side (div_side),
      .out_t    (div_t)
   );

   // scale the direction by t
   always_comb begin
      t_signed = $signed({1'b0, div_t});
      pl_px_in = div_side.dx * t_signed;
      pl_py_in = div_side.dy * t_signed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pl_vld_ff <= 1'b0;
      end else if (adv) begin
         pl_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_sx_ff <= div_side.sx;
         pl_sy_ff <= div_side.sy;
         pl_px_ff <= pl_px_in;
         pl_py_ff <= pl_py_in;
         pl_t_ff  <= div_t;
      end
   end

   // round half up and offset from the start point
   always_comb begin
      rx = (pl_px_ff + $signed(sci_pkg::PLACE_W'(1) << (sci_pkg::TFRAC - 1))) >>>
           sci_pkg::TFRAC;
      ry = (pl_py_ff + $signed(sci_pkg::PLACE_W'(1) << (sci_pkg::TFRAC - 1))) >>>
           sci_pkg::TFRAC;
      hit_x_in = pl_sx_ff + rx[sci_pkg::COORD_W-1:0];
      hit_y_in = pl_sy_ff + ry[sci_pkg::COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= pl_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_x_ff <= hit_x_in;
         hit_y_ff <= hit_y_in;
         hit_t_ff <= pl_t_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.hit_x = hit_x_ff;
   assign rsp.hit_y = hit_y_ff;
   assign rsp.hit_t = hit_t_ff;

endmodule

// File: bench/segment_circle_intersection_tb.sv
`timescale 1ns / 1ps

module segment_circle_intersection_tb;

   localparam int  ITEMS_PER_PHASE = 175;
   localparam int  NUM_PHASES      = 8;
   localparam int  DRAIN_CYCLES    = 80;
   localparam int  HOLD_CYCLES     = 400;
   localparam longint CYCLE_LIMIT  = 600000;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_HIT, ROW_MISS, ROW_CIRCLE} row_kind_type;

   typedef struct packed {
      logic signed [sci_pkg::COORD_W-1:0] start_x;
      logic signed [sci_pkg::COORD_W-1:0] start_y;
      logic signed [sci_pkg::COORD_W-1:0] end_x;
      logic signed [sci_pkg::COORD_W-1:0] end_y;
   } segment_type;

   typedef struct packed {
      logic signed [sci_pkg::COORD_W-1:0] x;
      logic signed [sci_pkg::COORD_W-1:0] y;
      logic [sci_pkg::T_W-1:0]            t;
   } hit_point_type;

   typedef struct packed {
      row_kind_type  kind;
      segment_type   seg;
      hit_point_type hit;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [sci_pkg::IDX_W-1:0]   csr_index;
   logic [sci_pkg::COORD_W-1:0] csr_wdata;

   sci_req_if req_ch ();
   sci_rsp_if rsp_ch ();

   segment_circle_intersection DUT (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Circle as the block should hold it
   longint circ_x, circ_y, circ_r;

   hit_point_type hits_due[$];
   int  mismatches;
   int  hits_seen;
   int  segs_sent;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_req;
   longint cycle_count;

   // Directed segments; circle rows carry center x, center y and radius in the first fields
   dir_row_type dir_rows[16] = '{
      '{ROW_PREDICT, '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}, '0},
      '{ROW_PREDICT, '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767}, '0},
      '{ROW_CIRCLE,  '{16'sd0, 16'sd0, 16'sd256, 16'sd0}, '0},
      '{ROW_HIT,     '{-16'sd512, 16'sd0, 16'sd512, 16'sd0}, '{-16'sd256, 16'sd0, 17'd16384}},
      '{ROW_MISS,    '{16'sd100, 16'sd100, 16'sd100, 16'sd100}, '0},
      '{ROW_MISS,    '{-16'sd512, 16'sd1024, 16'sd512, 16'sd1024}, '0},
      '{ROW_HIT,     '{-16'sd512, 16'sd256, 16'sd512, 16'sd256}, '{16'sd0, 16'sd256, 17'd32768}},
      '{ROW_MISS,    '{-16'sd64, 16'sd0, 16'sd64, 16'sd0}, '0},
      '{ROW_MISS,    '{-16'sd1024, 16'sd0, -16'sd512, 16'sd0}, '0},
      '{ROW_HIT,     '{16'sd0, 16'sd0, 16'sd256, 16'sd0}, '{16'sd256, 16'sd0, 17'd65536}},
      '{ROW_HIT,     '{16'sd256, 16'sd0, 16'sd0, 16'sd0}, '{16'sd256, 16'sd0, 17'd0}},
      '{ROW_PREDICT, '{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0}, '0},
      '{ROW_CIRCLE,  '{-16'sd32768, 16'sd32767, 16'sd32767, 16'sd0}, '0},
      '{ROW_PREDICT, '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768}, '0},
      '{ROW_PREDICT, '{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768}, '0},
      '{ROW_PREDICT, '{16'sd0, -16'sd1, -16'sd1, 16'sd0}, '0}
   };

   // Square root of a non-negative value, rounded to nearest
   function automatic longint root_nearest(input logic signed [127:0] v);
      logic signed [127:0] s;
      logic signed [127:0] cand;
      s = 0;
      for (int bitpos = 35; bitpos >= 0; bitpos--) begin
         cand = s | (128'sd1 <<< bitpos);
         if (cand * cand <= v) s = cand;
      end
      if (v - s * s > s) s = s + 1;
      return longint'(s);
   endfunction

   // Work out the hit of one segment on the current circle; returns 0 on a miss
   function automatic bit segment_hit(input segment_type seg, output hit_point_type hit);
      longint sx, sy, dx, dy, fx, fy, a, h, c, n, s, t, qx, qy;
      logic signed [127:0] hw, aw, cw, disc;
      hit = '0;
      sx = longint'(seg.start_x);
      sy = longint'(seg.start_y);
      dx = longint'(seg.end_x) - sx;
      dy = longint'(seg.end_y) - sy;
      fx = sx - circ_x;
      fy = sy - circ_y;
      a = dx * dx + dy * dy;
      h = fx * dx + fy * dy;
      c = fx * fx + fy * fy - circ_r * circ_r;
      if (a == 0) return 0;
      hw = h;
      aw = a;
      cw = c;
      disc = hw * hw - aw * cw;
      if (disc < 0) return 0;
      s = root_nearest(disc);
      // try the nearer root first
      n = -h - s;
      if (n < 0 || n > a) begin
         n = -h + s;
         if (n < 0 || n > a) return 0;
      end
      t = (n * 131072 + a) / (2 * a);
      qx = (dx * t + 32768) >>> sci_pkg::TFRAC;
      qy = (dy * t + 32768) >>> sci_pkg::TFRAC;
      hit.x = sci_pkg::COORD_W'(sx + qx);
      hit.y = sci_pkg::COORD_W'(sy + qy);
      hit.t = sci_pkg::T_W'(t);
      return 1;
   endfunction

   function automatic logic signed [sci_pkg::COORD_W-1:0] clamp16(input longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return sci_pkg::COORD_W'(v);
   endfunction

   // Random segment: mostly around the circle, some degenerate, some anywhere
   function automatic segment_type random_segment();
      segment_type seg;
      int mode;
      longint span;
      mode = $urandom_range(0, 99);
      span = 2 * circ_r + 2;
      if (mode < 72) begin
         seg.start_x = clamp16(circ_x + longint'($urandom_range(0, 32'(2 * span))) - span);
         seg.start_y = clamp16(circ_y + longint'($urandom_range(0, 32'(2 * span))) - span);
         seg.end_x   = clamp16(circ_x + longint'($urandom_range(0, 32'(2 * span))) - span);
         seg.end_y   = clamp16(circ_y + longint'($urandom_range(0, 32'(2 * span))) - span);
      end else begin
         seg = {$urandom(), $urandom()};
      end
      if (mode >= 72 && mode < 80) begin
         seg.end_x = seg.start_x;
         seg.end_y = seg.start_y;
      end
      return seg;
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle counter and timeout
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d hits outstanding", cycle_count,
                     hits_due.size());
            $display("segment_circle_intersection_tb NOT OK");
            $finish;
         end
      end
   end

   // Receiver: random stalls plus an occasional long hold-off
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Result check, sampled mid-cycle ahead of the accepting edge
   initial begin
      hit_point_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (hits_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected hit beat x=%0d y=%0d t=%0d", rsp_ch.hit_x,
                           rsp_ch.hit_y, rsp_ch.hit_t);
            end else begin
               want = hits_due.pop_front();
               hits_seen++;
               if (rsp_ch.hit_x !== want.x || rsp_ch.hit_y !== want.y ||
                   rsp_ch.hit_t !== want.t) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("hit mismatch: expected x=%0d y=%0d t=%0d, got x=%0d y=%0d t=%0d",
                              want.x, want.y, want.t, rsp_ch.hit_x, rsp_ch.hit_y,
                              rsp_ch.hit_t);
               end
            end
         end
      end
   end

   // Wait for every hit, then let the pipeline run dry
   task automatic drain_pipeline();
      while (hits_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Drive one register write; the caller drops the enable after the last one
   task automatic write_reg(input logic [sci_pkg::IDX_W-1:0] idx,
                            input logic [sci_pkg::COORD_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      case (idx)
         sci_pkg::REG_CENTER_X: circ_x = longint'($signed(value));
         sci_pkg::REG_CENTER_Y: circ_y = longint'($signed(value));
         sci_pkg::REG_RADIUS:   circ_r = longint'(value[sci_pkg::RAD_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic set_circle(input logic [sci_pkg::COORD_W-1:0] cx,
                             input logic [sci_pkg::COORD_W-1:0] cy,
                             input logic [sci_pkg::COORD_W-1:0] r);
      // stop offering segments while the circle changes
      req_ch.valid <= 1'b0;
      drain_pipeline();
      write_reg(sci_pkg::REG_CENTER_X, cx);
      write_reg(sci_pkg::REG_CENTER_Y, cy);
      write_reg(sci_pkg::REG_RADIUS, r);
      // index past the radius must be ignored
      write_reg(sci_pkg::REG_RADIUS + 2'd1, 16'hffff);
      csr_write_en <= 1'b0;
   endtask

   // Offer one segment beat and hold it until accepted
   task automatic send_segment(input segment_type seg, input row_kind_type kind,
                               input hit_point_type fixed_hit);
      hit_point_type hit;
      bit fire;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.start_x <= seg.start_x;
      req_ch.start_y <= seg.start_y;
      req_ch.end_x   <= seg.end_x;
      req_ch.end_y   <= seg.end_y;
      fire = 1'b0;
      while (!fire) begin
         @(negedge clock);
         fire = req_ch.valid && req_ch.ready;
         if (fire) begin
            segs_sent++;
            if (kind == ROW_HIT) hits_due = {hits_due, fixed_hit};
            else if (kind == ROW_PREDICT && segment_hit(seg, hit)) hits_due = {hits_due, hit};
         end
         @(posedge clock);
      end
   endtask

   // Main sequence
   initial begin
      int send_pat[4];
      int stall_pat[4];
      send_pat  = '{0, 74, 0, 19};
      stall_pat = '{0, 0, 74, 19};
      reset        = 1'b1;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_ch.valid   = 1'b0;
      req_ch.start_x = '0;
      req_ch.start_y = '0;
      req_ch.end_x   = '0;
      req_ch.end_y   = '0;
      circ_x = 0;
      circ_y = 0;
      circ_r = 0;
      mismatches = 0;
      hits_seen = 0;
      segs_sent = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CIRCLE) begin
            set_circle(dir_rows[i].seg.start_x, dir_rows[i].seg.start_y,
                       dir_rows[i].seg.end_x);
         end else begin
            send_segment(dir_rows[i].seg, dir_rows[i].kind, dir_rows[i].hit);
         end
      end

      // Random phases over several circles and idling patterns
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         case (ph)
            0: set_circle(16'h0000, 16'h0000, 16'h0000);
            1: set_circle(16'h8000, 16'h8000, 16'h7fff);
            2: set_circle(16'h7fff, 16'h7fff, 16'hffff);
            3: set_circle(16'h0000, 16'h0000, 16'h0100);
            default: set_circle(16'($urandom()), 16'($urandom()),
                                16'($urandom_range(0, 16'h2000)));
         endcase
         send_idle_pct  = send_pat[ph % 4];
         recv_stall_pct = stall_pat[ph % 4];
         if (ph == 1) hold_req = 1'b1;
         for (int k = 0; k < ITEMS_PER_PHASE; k++)
            send_segment(random_segment(), ROW_PREDICT, '0);
      end
      req_ch.valid <= 1'b0;
      drain_pipeline();

      $display("sent %0d segments over %0d circles, checked %0d hit beats", segs_sent,
               NUM_PHASES + 2, hits_seen);
      $display("idle, stall and hold-off patterns covered, %0d mismatches", mismatches);
      if (mismatches == 0 && hits_due.size() == 0) begin
         $display("segment_circle_intersection_tb OK");
      end else begin
         $display("segment_circle_intersection_tb NOT OK");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/sci_pkg.sv
hdl/sci_req_if.sv
hdl/sci_rsp_if.sv
hdl/sci_quad.sv
hdl/sci_sqrt.sv
hdl/sci_div.sv
hdl/segment_circle_intersection.sv
bench/segment_circle_intersection_tb.sv
